[sv/prpi_pkg.sv]
`default_nettype none
package prpi_pkg;

  localparam int NODES = 16;
  localparam int IDXW  = $clog2(NODES);
  localparam int DEGW  = $clog2(NODES + 1);
  localparam int CNTW  = $clog2(NODES + 3);
  localparam int RANKW = 32;
  localparam int WW    = 33;                    // link weight, Q1.32
  localparam int DIVW  = 33;                    // divider dividend and quotient
  localparam int PRODW = WW + RANKW;
  localparam int ACCW  = WW + IDXW;
  localparam int SQW   = 2 * RANKW - 20;
  localparam int SUMW  = SQW + IDXW;

  localparam logic [RANKW-1:0] START_RANK = RANKW'((64'(1) << 30) / NODES);

  localparam logic [1:0] CFG_DAMPING   = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [1:0] CFG_MAX_ITER  = 2'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DEGREE,
    ST_TELE_GO,
    ST_LINK_GO,
    ST_LINK_WAIT,
    ST_INIT,
    ST_CHANGE,
    ST_CHECK,
    ST_MUL,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             deg_en;
    logic             init;
    logic             mul_start;
    logic             commit;
    logic             bc_valid;
    logic [IDXW-1:0]  bc_idx;
    logic [RANKW-1:0] bc_link;
    logic [RANKW-1:0] bc_p;
  } lane_ctl_t;

  typedef struct packed {
    logic [DEGW-1:0]  deg;
    logic [RANKW-1:0] cur;
    logic [RANKW-1:0] prev;
    logic [SQW-1:0]   sq;
  } lane_out_t;

endpackage
`default_nettype wire

[sv/prpi_divider.sv]
`default_nettype none
module prpi_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [prpi_pkg::DIVW-1:0]  dividend,
  input  wire logic [prpi_pkg::DEGW-1:0]  divisor,
  output logic                            done,
  output logic [prpi_pkg::DIVW-1:0]       quotient
);

  logic                        busy;
  logic [5:0]                  count;
  logic [prpi_pkg::DEGW-1:0]   rem;
  logic [prpi_pkg::DEGW:0]     trial;
  logic                        ge;

  // one quotient bit a cycle, restoring
  assign trial = {rem, quotient[prpi_pkg::DIVW-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'(prpi_pkg::DIVW);
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? prpi_pkg::DEGW'(trial - {1'b0, divisor}) : trial[prpi_pkg::DEGW-1:0];
      quotient <= {quotient[prpi_pkg::DIVW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[sv/prpi_lane.sv]
`default_nettype none
module prpi_lane (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [prpi_pkg::IDXW-1:0]   lane_id,
  input  wire logic                        row_we,
  input  wire logic [3:0]                  row_index,
  input  wire logic [15:0]                 row_bits,
  input  wire logic [prpi_pkg::RANKW-1:0]  tele,
  input  wire prpi_pkg::lane_ctl_t         ctl,
  output prpi_pkg::lane_out_t              lo
);

  logic [prpi_pkg::NODES-1:0] row;
  logic [prpi_pkg::DEGW-1:0]  deg;
  logic [prpi_pkg::RANKW-1:0] cur;
  logic [prpi_pkg::RANKW-1:0] prev;
  logic [prpi_pkg::RANKW-1:0] diff;
  logic [2*prpi_pkg::RANKW-1:0] sq;
  logic [prpi_pkg::WW-1:0]    w;
  logic [prpi_pkg::RANKW-1:0] p;
  logic [prpi_pkg::PRODW-1:0] prod;
  logic [prpi_pkg::ACCW-1:0]  acc;
  logic                       v1;
  logic                       v2;

  always_ff @(posedge clk) begin
    if (row_we && (8'(row_index) == 8'(lane_id))) begin
      row <= prpi_pkg::NODES'(row_bits);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deg <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
    end else begin
      if (ctl.deg_en) begin
        deg <= prpi_pkg::DEGW'($countones(row));
      end
      v1 <= ctl.bc_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      cur  <= prpi_pkg::START_RANK;
      prev <= '0;
    end else if (ctl.mul_start) begin
      prev <= cur;
    end else if (ctl.commit) begin
      cur <= (acc > prpi_pkg::ACCW'({prpi_pkg::RANKW{1'b1}})) ?
             {prpi_pkg::RANKW{1'b1}} : acc[prpi_pkg::RANKW-1:0];
    end
    if (ctl.bc_valid) begin
      w <= prpi_pkg::WW'(tele) +
           (row[ctl.bc_idx] ? prpi_pkg::WW'(ctl.bc_link) : '0);
      p <= ctl.bc_p;
    end
    prod <= prpi_pkg::PRODW'(w) * prpi_pkg::PRODW'(p);
    if (ctl.mul_start) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + prpi_pkg::ACCW'(prod[prpi_pkg::PRODW-1:32]);
    end
    // squared change runs freely behind the rank registers
    diff <= (cur >= prev) ? cur - prev : prev - cur;
    sq   <= (2*prpi_pkg::RANKW)'(diff) * (2*prpi_pkg::RANKW)'(diff);
  end

  always_comb begin
    lo.deg  = deg;
    lo.cur  = cur;
    lo.prev = prev;
    lo.sq   = sq[2*prpi_pkg::RANKW-1:20];
  end

endmodule
`default_nettype wire

[sv/prpi_merge.sv]
`default_nettype none
module prpi_merge (
  input  wire logic                      clk,
  input  wire logic                      clear,
  input  wire logic                      add_en,
  input  wire logic [prpi_pkg::SQW-1:0]  value,
  input  wire logic [31:0]               tolerance,
  output logic                           over
);

  logic [prpi_pkg::SUMW-1:0] sum;

  always_ff @(posedge clk) begin
    if (clear) begin
      sum <= '0;
    end else if (add_en) begin
      sum <= sum + prpi_pkg::SUMW'(value);
    end
  end

  assign over = sum > prpi_pkg::SUMW'(tolerance);

endmodule
`default_nettype wire

[sv/pagerank_power_iteration.sv]
// PageRank by power iteration over a graph of up to 16 nodes. Send the
// adjacency rows one beat each on the slave stream; the beat with tlast set
// starts a run, and rows not rewritten keep their old contents. One lane per
// node holds that node's row, degree and rank; every matrix-vector product
// walks the columns through all lanes at once, one column a cycle, and a
// merging stage sums the squared rank changes one lane a cycle. Setup runs
// the shared bit-serial divider once for each column's link share (the
// teleport share is a plain shift), then the iterations follow, and at the
// end the 16 rank beats leave on the master stream. No new row is taken
// until the last rank beat has gone. Configuration writes belong in the idle
// time between runs.
`default_nettype none
module pagerank_power_iteration (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // row_index[3:0], row_bits[19:4], zero
  input  wire logic        s_axis_tlast,   // last_row
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // node_index[3:0], rank[35:4], zero
  output logic             m_axis_tlast,   // last_node
  output logic [1:0]       m_axis_tuser    // converged[0], dangling_seen[1]
);

  localparam int N    = prpi_pkg::NODES;
  localparam int IDXW = prpi_pkg::IDXW;
  localparam int CNTW = prpi_pkg::CNTW;

  prpi_pkg::state_t    state;
  prpi_pkg::state_t    state_next;

  logic [15:0]         damping;
  logic [31:0]         tolerance;
  logic [15:0]         max_iterations;
  logic [15:0]         iter;
  logic [CNTW-1:0]     cnt;
  logic [IDXW-1:0]     j;
  logic [IDXW-1:0]     sel;
  logic [31:0]         tele;
  logic [31:0]         link_tab [N];
  logic                converged;
  logic                dangling;
  logic                in_acc;
  logic                out_acc;

  logic                div_start;
  logic [prpi_pkg::DIVW-1:0] div_dividend;
  logic [prpi_pkg::DEGW-1:0] div_divisor;
  logic                div_done;
  logic [prpi_pkg::DIVW-1:0] div_quo;

  logic                merge_clear;
  logic                merge_add;
  logic                over;

  logic                bc_valid;
  logic [IDXW-1:0]     bc_idx;
  logic [31:0]         bc_link;
  logic [31:0]         bc_p;

  prpi_pkg::lane_ctl_t ctl;
  prpi_pkg::lane_out_t lane_o [N];
  logic [N-1:0]        deg_zero;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;
  assign j       = cnt[IDXW-1:0];
  assign sel     = IDXW'(cnt - CNTW'(2));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      damping        <= 16'd58982;
      tolerance      <= 32'd10995;
      max_iterations <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        prpi_pkg::CFG_DAMPING:   damping        <= cfg_data[15:0];
        prpi_pkg::CFG_TOLERANCE: tolerance      <= cfg_data;
        prpi_pkg::CFG_MAX_ITER:  max_iterations <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      prpi_pkg::ST_LOAD: begin
        if (in_acc && s_axis_tlast) state_next = prpi_pkg::ST_DEGREE;
      end
      prpi_pkg::ST_DEGREE:    state_next = prpi_pkg::ST_TELE_GO;
      prpi_pkg::ST_TELE_GO:   state_next = prpi_pkg::ST_LINK_GO;
      prpi_pkg::ST_LINK_GO:   state_next = prpi_pkg::ST_LINK_WAIT;
      prpi_pkg::ST_LINK_WAIT: begin
        if (div_done) begin
          state_next = (j == IDXW'(N - 1)) ? prpi_pkg::ST_INIT : prpi_pkg::ST_LINK_GO;
        end
      end
      prpi_pkg::ST_INIT:      state_next = prpi_pkg::ST_CHANGE;
      prpi_pkg::ST_CHANGE: begin
        if (cnt == CNTW'(N + 1)) state_next = prpi_pkg::ST_CHECK;
      end
      prpi_pkg::ST_CHECK: begin
        state_next = (over && (iter < max_iterations)) ? prpi_pkg::ST_MUL : prpi_pkg::ST_EMIT;
      end
      prpi_pkg::ST_MUL:       if (cnt == CNTW'(N - 1)) state_next = prpi_pkg::ST_DRAIN;
      prpi_pkg::ST_DRAIN:     if (cnt == CNTW'(3)) state_next = prpi_pkg::ST_CHANGE;
      prpi_pkg::ST_EMIT: begin
        if (out_acc && (j == IDXW'(N - 1))) state_next = prpi_pkg::ST_LOAD;
      end
      default:                state_next = prpi_pkg::ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state == prpi_pkg::ST_LOAD);
    m_axis_tvalid = (state == prpi_pkg::ST_EMIT);
    div_start     = (state == prpi_pkg::ST_LINK_GO);
    div_dividend  = prpi_pkg::DIVW'({damping, 16'h0000});
    div_divisor   = lane_o[j].deg;
    merge_clear   = (state == prpi_pkg::ST_INIT) ||
                    ((state == prpi_pkg::ST_DRAIN) && (cnt == CNTW'(3)));
    merge_add     = (state == prpi_pkg::ST_CHANGE) && (cnt >= CNTW'(2));
    ctl.deg_en    = (state == prpi_pkg::ST_DEGREE);
    ctl.init      = (state == prpi_pkg::ST_INIT);
    ctl.mul_start = (state == prpi_pkg::ST_CHECK) && over && (iter < max_iterations);
    ctl.commit    = (state == prpi_pkg::ST_DRAIN) && (cnt == CNTW'(3));
    ctl.bc_valid  = bc_valid;
    ctl.bc_idx    = bc_idx;
    ctl.bc_link   = bc_link;
    ctl.bc_p      = bc_p;
    m_axis_tdata  = {4'h0, lane_o[j].cur, 4'(j)};
    m_axis_tlast  = (j == IDXW'(N - 1));
    m_axis_tuser  = {dangling, converged};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= prpi_pkg::ST_LOAD;
      cnt      <= '0;
      iter     <= '0;
      bc_valid <= 1'b0;
    end else begin
      state    <= state_next;
      bc_valid <= (state == prpi_pkg::ST_MUL);
      unique case (state)
        prpi_pkg::ST_LOAD, prpi_pkg::ST_INIT, prpi_pkg::ST_CHECK: begin
          cnt <= '0;
          if (state == prpi_pkg::ST_INIT) iter <= '0;
          if (ctl.mul_start) iter <= iter + 16'd1;
        end
        prpi_pkg::ST_LINK_WAIT: if (div_done) cnt <= cnt + CNTW'(1);
        prpi_pkg::ST_CHANGE:    cnt <= (cnt == CNTW'(N + 1)) ? '0 : cnt + CNTW'(1);
        prpi_pkg::ST_MUL:       cnt <= (cnt == CNTW'(N - 1)) ? '0 : cnt + CNTW'(1);
        prpi_pkg::ST_DRAIN:     cnt <= (cnt == CNTW'(3)) ? '0 : cnt + CNTW'(1);
        prpi_pkg::ST_EMIT:      if (out_acc) cnt <= cnt + CNTW'(1);
        default: ;
      endcase
    end
  end

  // payload side of the sequencer
  always_ff @(posedge clk) begin
    bc_idx  <= j;
    bc_link <= link_tab[j];
    bc_p    <= lane_o[j].prev;
    if (state == prpi_pkg::ST_TELE_GO) begin
      dangling <= |deg_zero;
      // teleport share: the node count is a power of two, so this is a shift
      tele     <= 32'({17'h10000 - {1'b0, damping}, 16'h0000} / 33'(N));
    end
    if ((state == prpi_pkg::ST_LINK_WAIT) && div_done) begin
      // a column of degree zero takes the teleport share only
      link_tab[j] <= (lane_o[j].deg == '0) ? 32'h0 : div_quo[31:0];
    end
    if (state == prpi_pkg::ST_CHECK) converged <= !over;
  end

  prpi_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  for (genvar g = 0; g < N; g++) begin : g_lane
    prpi_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .lane_id   (IDXW'(g)),
      .row_we    (in_acc),
      .row_index (s_axis_tdata[3:0]),
      .row_bits  (s_axis_tdata[19:4]),
      .tele      (tele),
      .ctl       (ctl),
      .lo        (lane_o[g])
    );
    assign deg_zero[g] = (lane_o[g].deg == '0);
  end

  prpi_merge u_merge (
    .clk       (clk),
    .clear     (merge_clear),
    .add_en    (merge_add),
    .value     (lane_o[sel].sq),
    .tolerance (tolerance),
    .over      (over)
  );

endmodule
`default_nettype wire
